>>> rtl/core/lrud_pkg.sv
package lrud_pkg;

    // default number of directory slots
    localparam int ENTRIES_DEFAULT = 8;

    // slot index and rank width in the token, wide enough for 32 slots
    localparam int IDX_W = 5;

    // field widths
    localparam int BLOCK_W  = 16;
    localparam int OFF_W    = 9;
    localparam int CUROFF_W = 10;
    localparam int SLOT_W   = 3;
    localparam int ADDR_W   = 12;
    localparam int FILL_W   = 17;
    localparam int NUM_W    = 16;
    localparam int LOWOFF_W = 7;

    // item kinds
    localparam logic KIND_OPEN = 1'b0;
    localparam logic KIND_NEXT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } lrud_state_t;

    typedef struct packed {
        logic             kind;
        logic [NUM_W-1:0] message_number;
    } in_item_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  byte_offset;
        logic [ADDR_W-1:0] buffer_address;
        logic [FILL_W-1:0] fill_block;
    } out_item_t;

    // lookup token walking down the row of cells
    typedef struct packed {
        logic               active;
        logic [BLOCK_W-1:0] blk;
        logic               hit;
        logic [IDX_W-1:0]   hit_slot;
        logic [IDX_W-1:0]   hit_rank;
        logic [IDX_W-1:0]   victim_slot;
    } token_t;

    // promote / replace broadcast to every cell
    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   slot;
        logic [IDX_W-1:0]   rank;
        logic [BLOCK_W-1:0] blk;
    } commit_t;

endpackage

>>> rtl/core/lrud_cell.sv
module lrud_cell #(
    parameter int ENTRIES  = lrud_pkg::ENTRIES_DEFAULT,
    parameter int CELL_IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  lrud_pkg::token_t  tok_in,
    input  lrud_pkg::commit_t commit,
    output lrud_pkg::token_t  tok_out
);

    localparam int RANK_W = $clog2(ENTRIES);

    logic [lrud_pkg::BLOCK_W-1:0] tag_reg;
    logic                         valid_reg;
    logic [RANK_W-1:0]            rank_reg;

    lrud_pkg::token_t tok_reg;
    lrud_pkg::token_t tok_next;

    logic match;
    logic is_lru;
    logic is_sel;
    logic younger;

    // compare against the passing token
    always_comb begin
        match   = tok_in.active && valid_reg && (tag_reg == tok_in.blk);
        is_lru  = (rank_reg == RANK_W'(ENTRIES - 1));
        is_sel  = (commit.slot == lrud_pkg::IDX_W'(CELL_IDX));
        younger = (lrud_pkg::IDX_W'(rank_reg) < commit.rank);

        tok_next = tok_in;
        if (match) begin
            tok_next.hit      = 1'b1;
            tok_next.hit_slot = lrud_pkg::IDX_W'(CELL_IDX);
            tok_next.hit_rank = lrud_pkg::IDX_W'(rank_reg);
        end
        if (is_lru) begin
            tok_next.victim_slot = lrud_pkg::IDX_W'(CELL_IDX);
        end
    end

    // hand the token to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    // slot state: promote on commit, others age when younger
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg   <= '0;
            valid_reg <= 1'b0;
            rank_reg  <= RANK_W'(CELL_IDX);
        end else if (commit.valid) begin
            if (is_sel) begin
                tag_reg   <= commit.blk;
                valid_reg <= 1'b1;
                rank_reg  <= '0;
            end else if (younger) begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> rtl/core/message_block_lru_directory.sv
// Fully associative LRU directory for 512-byte message blocks.
// Input channel s_*: one beat is an open (message number) or a next-byte
// request. Output channel m_*: one result beat per input beat, giving
// hit, slot, byte offset, buffer address and, on a miss, the file block
// to fill (base_block + block).
// Config channel cfg_*: writes base_block; always ready. The user must
// see that it is written while idle; the block does not enforce this.
// A lookup token walks the row of ENTRIES cells, one cell per cycle,
// then the chosen slot is promoted by a broadcast commit, which waits
// until the output register is free. s_ready is high only while idle,
// so a new item is taken only after the previous lookup has committed.
// The result sits in an output register: a new beat is accepted while an
// earlier result still waits, but a finished lookup holds in the result
// state until the output register is free, so a stalled receiver stops
// the block after one item.
// Reset (synchronous, active low) empties all slots, sets slot i to rank i,
// clears base_block and the current block and offset.
module message_block_lru_directory #(
    parameter int ENTRIES = lrud_pkg::ENTRIES_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  lrud_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output lrud_pkg::out_item_t          m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lrud_pkg::BLOCK_W-1:0] cfg_data
);

    lrud_pkg::lrud_state_t state_reg;
    lrud_pkg::lrud_state_t state_next;

    logic [lrud_pkg::BLOCK_W-1:0]  base_reg;
    logic [lrud_pkg::BLOCK_W-1:0]  cur_block_reg;
    logic [lrud_pkg::BLOCK_W-1:0]  cur_block_next;
    logic [lrud_pkg::CUROFF_W-1:0] cur_off_reg;
    logic [lrud_pkg::CUROFF_W-1:0] cur_off_next;
    logic [lrud_pkg::OFF_W-1:0]    off_reg;
    logic [lrud_pkg::OFF_W-1:0]    off_next;
    lrud_pkg::token_t              final_reg;
    lrud_pkg::token_t              final_next;
    logic                          m_valid_reg;
    logic                          m_valid_next;
    lrud_pkg::out_item_t           m_data_reg;
    lrud_pkg::out_item_t           m_data_next;

    logic                          accept;
    logic                          out_free;
    logic [lrud_pkg::BLOCK_W-1:0]  item_blk;
    logic [lrud_pkg::OFF_W-1:0]    item_off;
    lrud_pkg::commit_t             commit;
    lrud_pkg::token_t              tok [ENTRIES+1];

    assign s_ready   = (state_reg == lrud_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // block and offset of the incoming beat, and the advanced position
    always_comb begin
        item_blk       = cur_block_reg;
        item_off       = cur_off_reg[lrud_pkg::OFF_W-1:0];
        cur_block_next = cur_block_reg;
        cur_off_next   = cur_off_reg;
        if (s_data.kind == lrud_pkg::KIND_OPEN) begin
            item_blk = {7'd0, s_data.message_number[lrud_pkg::NUM_W-1:lrud_pkg::LOWOFF_W]};
            item_off = {s_data.message_number[lrud_pkg::LOWOFF_W-1:0], 2'b00};
            if (accept) begin
                cur_block_next = item_blk;
                cur_off_next   = {1'b0, item_off};
            end
        end else begin
            if (cur_off_reg[lrud_pkg::CUROFF_W-1]) begin
                item_blk = cur_block_reg + lrud_pkg::BLOCK_W'(1);
                item_off = '0;
            end
            if (accept) begin
                cur_block_next = item_blk;
                cur_off_next   = {1'b0, item_off} + lrud_pkg::CUROFF_W'(1);
            end
        end
    end

    // token into the first cell
    always_comb begin
        tok[0]        = '0;
        tok[0].active = accept;
        tok[0].blk    = item_blk;
    end

    // row of cells
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        lrud_cell #(
            .ENTRIES  (ENTRIES),
            .CELL_IDX (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok[i]),
            .commit  (commit),
            .tok_out (tok[i+1])
        );
    end

    // sequencer: walk, then commit and load the result
    always_comb begin
        state_next   = state_reg;
        off_next     = off_reg;
        final_next   = final_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        commit       = '0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            lrud_pkg::ST_IDLE: begin
                if (accept) begin
                    off_next   = item_off;
                    state_next = lrud_pkg::ST_WALK;
                end
            end
            lrud_pkg::ST_WALK: begin
                if (tok[ENTRIES].active) begin
                    final_next = tok[ENTRIES];
                    state_next = lrud_pkg::ST_RESULT;
                end
            end
            lrud_pkg::ST_RESULT: begin
                commit.blk = final_reg.blk;
                if (final_reg.hit) begin
                    commit.slot = final_reg.hit_slot;
                    commit.rank = final_reg.hit_rank;
                end else begin
                    commit.slot = final_reg.victim_slot;
                    commit.rank = lrud_pkg::IDX_W'(ENTRIES - 1);
                end
                if (out_free) begin
                    commit.valid               = 1'b1;
                    m_valid_next               = 1'b1;
                    m_data_next.hit            = final_reg.hit;
                    m_data_next.slot           = commit.slot[lrud_pkg::SLOT_W-1:0];
                    m_data_next.byte_offset    = off_reg;
                    m_data_next.buffer_address = {commit.slot[lrud_pkg::SLOT_W-1:0], off_reg};
                    if (final_reg.hit) begin
                        m_data_next.fill_block = '0;
                    end else begin
                        m_data_next.fill_block = {1'b0, base_reg} + {1'b0, final_reg.blk};
                    end
                    state_next = lrud_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lrud_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lrud_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            base_reg      <= '0;
            cur_block_reg <= '0;
            cur_off_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            cur_block_reg <= cur_block_next;
            cur_off_reg   <= cur_off_next;
            if (cfg_valid && cfg_ready) begin
                base_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        off_reg    <= off_next;
        final_reg  <= final_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a token leaves the row only while walking
    a_token_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[ENTRIES].active |-> (state_reg == lrud_pkg::ST_WALK))
        else $error("lookup token left the cell row outside the walk");

    // an accepted beat starts a walk
    a_accept_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == lrud_pkg::ST_WALK))
        else $error("accepted beat did not start a walk");

    // a hit never asks for a fill
    a_hit_no_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.hit) |-> (m_data.fill_block == '0))
        else $error("hit result carries a fill block");

    // commit only when the output register can take the result
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        commit.valid |=> (m_valid && (state_reg == lrud_pkg::ST_IDLE)))
        else $error("commit without a loaded result");

endmodule

>>> tb/sv/tb_message_block_lru_directory.sv
`timescale 1ns / 100ps

module tb_message_block_lru_directory;

    localparam int ENTRIES     = lrud_pkg::ENTRIES_DEFAULT;
    localparam int DIR_ROWS    = 21;
    localparam int PHASE_ITEMS = 112;
    localparam int POOL_SIZE   = 12;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        lrud_pkg::in_item_t  item;
        bit                  typed;
        lrud_pkg::out_item_t want;
    } stim_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    lrud_pkg::in_item_t            s_data;
    logic                          m_valid;
    logic                          m_ready;
    lrud_pkg::out_item_t           m_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [lrud_pkg::BLOCK_W-1:0]  cfg_data;

    // directory mirror
    logic [lrud_pkg::BLOCK_W-1:0]  block_tag    [ENTRIES];
    logic                          block_cached [ENTRIES];
    logic [lrud_pkg::IDX_W-1:0]    block_rank   [ENTRIES];
    logic [lrud_pkg::BLOCK_W-1:0]  cur_block;
    logic [lrud_pkg::CUROFF_W-1:0] cur_offset;
    logic [lrud_pkg::BLOCK_W-1:0]  base_reg;

    lrud_pkg::out_item_t           pending_results [$];
    stim_row_t                     dir_rows [DIR_ROWS];
    logic [8:0]                    block_pool [POOL_SIZE];
    int                            errors;
    int                            cycles;
    int                            src_idle_pct;
    int                            sink_stall_pct;

    message_block_lru_directory #(
        .ENTRIES (ENTRIES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // make slot s most recent, younger slots age by one
    function automatic void promote_slot(int s);
        logic [lrud_pkg::IDX_W-1:0] r;
        r = block_rank[s];
        for (int i = 0; i < ENTRIES; i++) begin
            if (block_rank[i] < r) begin
                block_rank[i] = block_rank[i] + lrud_pkg::IDX_W'(1);
            end
        end
        block_rank[s] = '0;
    endfunction

    // advance the cursor, look the block up and update recency
    function automatic lrud_pkg::out_item_t predict_access(lrud_pkg::in_item_t it);
        lrud_pkg::out_item_t        r;
        int                         found;
        int                         victim;
        logic [lrud_pkg::OFF_W-1:0] off;
        found  = -1;
        victim = 0;
        if (it.kind == lrud_pkg::KIND_OPEN) begin
            cur_block  = {7'd0, it.message_number[lrud_pkg::NUM_W-1:lrud_pkg::LOWOFF_W]};
            cur_offset = {1'b0, it.message_number[lrud_pkg::LOWOFF_W-1:0], 2'b00};
        end else if (cur_offset >= 10'd512) begin
            cur_block  = cur_block + lrud_pkg::BLOCK_W'(1);
            cur_offset = '0;
        end
        off = cur_offset[lrud_pkg::OFF_W-1:0];
        for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && block_cached[i] && block_tag[i] == cur_block) begin
                found = i;
            end
        end
        if (found >= 0) begin
            r.hit        = 1'b1;
            r.fill_block = '0;
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (block_rank[i] == lrud_pkg::IDX_W'(ENTRIES - 1)) begin
                    victim = i;
                end
            end
            block_tag[victim]    = cur_block;
            block_cached[victim] = 1'b1;
            found                = victim;
            r.hit                = 1'b0;
            r.fill_block         = {1'b0, base_reg} + {1'b0, cur_block};
        end
        promote_slot(found);
        r.slot           = found[lrud_pkg::SLOT_W-1:0];
        r.byte_offset    = off;
        r.buffer_address = {found[lrud_pkg::SLOT_W-1:0], off};
        if (it.kind == lrud_pkg::KIND_NEXT) begin
            cur_offset = cur_offset + lrud_pkg::CUROFF_W'(1);
        end
        return r;
    endfunction

    function automatic void check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
            errors++;
        end
    endfunction

    // one input beat; entered and left at a falling edge
    task automatic send_item(input lrud_pkg::in_item_t it, input bit typed,
                             input lrud_pkg::out_item_t want);
        lrud_pkg::out_item_t predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_access(it);
        pending_results.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    // wait until every expected result has come, end on a falling edge
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // base_block write, only while idle
    task automatic write_base(input logic [lrud_pkg::BLOCK_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        base_reg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin : result_check
        lrud_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat, got %p", $time, m_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(m_data.hit));
                check_field("slot", 32'(want.slot), 32'(m_data.slot));
                check_field("byte_offset", 32'(want.byte_offset), 32'(m_data.byte_offset));
                check_field("buffer_address", 32'(want.buffer_address),
                            32'(m_data.buffer_address));
                check_field("fill_block", 32'(want.fill_block), 32'(m_data.fill_block));
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [lrud_pkg::BLOCK_W-1:0] phase_base [4];
        int                           phase_idle [4];
        int                           phase_stall [4];
        int                           sent;
        int                           run_len;
        int                           pick;
        bit                           paused;
        lrud_pkg::in_item_t           it;
        lrud_pkg::out_item_t          none;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        errors         = 0;
        cycles         = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        paused         = 1'b0;
        none           = '0;

        // mirror reset state
        for (int i = 0; i < ENTRIES; i++) begin
            block_tag[i]    = '0;
            block_cached[i] = 1'b0;
            block_rank[i]   = i[lrud_pkg::IDX_W-1:0];
        end
        cur_block  = '0;
        cur_offset = '0;
        base_reg   = '0;

        // next byte before any open, block crossing, eviction and refill
        dir_rows[0]  = '{'{lrud_pkg::KIND_NEXT, 16'hFFFF}, 1'b1,
                         '{1'b0, 3'd7, 9'd0, 12'd3584, 17'd0}};
        dir_rows[1]  = '{'{lrud_pkg::KIND_NEXT, 16'h0000}, 1'b1,
                         '{1'b1, 3'd7, 9'd1, 12'd3585, 17'd0}};
        dir_rows[2]  = '{'{lrud_pkg::KIND_OPEN, 16'hFFFF}, 1'b1,
                         '{1'b0, 3'd6, 9'd508, 12'd3580, 17'd511}};
        dir_rows[3]  = '{'{lrud_pkg::KIND_OPEN, 16'h0000}, 1'b1,
                         '{1'b1, 3'd7, 9'd0, 12'd3584, 17'd0}};
        dir_rows[4]  = '{'{lrud_pkg::KIND_OPEN, 16'h007F}, 1'b1,
                         '{1'b1, 3'd7, 9'd508, 12'd4092, 17'd0}};
        dir_rows[5]  = '{'{lrud_pkg::KIND_NEXT, 16'h5555}, 1'b0, none};
        dir_rows[6]  = '{'{lrud_pkg::KIND_NEXT, 16'hAAAA}, 1'b0, none};
        dir_rows[7]  = '{'{lrud_pkg::KIND_NEXT, 16'h1234}, 1'b0, none};
        dir_rows[8]  = '{'{lrud_pkg::KIND_NEXT, 16'h8000}, 1'b0, none};
        dir_rows[9]  = '{'{lrud_pkg::KIND_NEXT, 16'h0001}, 1'b0, none};
        dir_rows[10] = '{'{lrud_pkg::KIND_NEXT, 16'h7FFF}, 1'b0, none};
        dir_rows[11] = '{'{lrud_pkg::KIND_OPEN, 16'h0100}, 1'b0, none};
        dir_rows[12] = '{'{lrud_pkg::KIND_OPEN, 16'h01AA}, 1'b0, none};
        dir_rows[13] = '{'{lrud_pkg::KIND_OPEN, 16'h0255}, 1'b0, none};
        dir_rows[14] = '{'{lrud_pkg::KIND_OPEN, 16'h02FF}, 1'b0, none};
        dir_rows[15] = '{'{lrud_pkg::KIND_OPEN, 16'h0301}, 1'b0, none};
        dir_rows[16] = '{'{lrud_pkg::KIND_OPEN, 16'h03C0}, 1'b0, none};
        dir_rows[17] = '{'{lrud_pkg::KIND_OPEN, 16'h0000}, 1'b0, none};
        dir_rows[18] = '{'{lrud_pkg::KIND_OPEN, 16'hFF80}, 1'b0, none};
        dir_rows[19] = '{'{lrud_pkg::KIND_OPEN, 16'h0155}, 1'b0, none};
        dir_rows[20] = '{'{lrud_pkg::KIND_NEXT, 16'hAAAA}, 1'b0, none};

        // per phase: base block, sender idle and receiver stall
        phase_base[0]  = 16'hFFFF;
        phase_base[1]  = lrud_pkg::BLOCK_W'($urandom_range(16'hFFFE, 1));
        phase_base[2]  = 16'h8001;
        phase_base[3]  = 16'h0000;
        phase_idle[0]  = 0;
        phase_idle[1]  = 67;
        phase_idle[2]  = 0;
        phase_idle[3]  = 37;
        phase_stall[0] = 0;
        phase_stall[1] = 0;
        phase_stall[2] = 67;
        phase_stall[3] = 37;

        // pool of blocks that messages keep coming back to
        block_pool[0] = 9'd0;
        block_pool[1] = 9'd511;
        for (int i = 2; i < POOL_SIZE; i++) begin
            block_pool[i] = 9'($urandom_range(510, 1));
        end

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        write_base(16'h0000);
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            write_base(phase_base[ph]);
            src_idle_pct   = phase_idle[ph];
            sink_stall_pct = phase_stall[ph];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // sender holds off until the block is empty
                if (ph == 1 && !paused && sent >= PHASE_ITEMS / 2) begin
                    drain_results();
                    paused = 1'b1;
                end
                pick = $urandom_range(99);
                if (pick < 75) begin
                    // open from the pool, often near a block end, then read on
                    it.kind = lrud_pkg::KIND_OPEN;
                    it.message_number[lrud_pkg::NUM_W-1:lrud_pkg::LOWOFF_W] =
                        block_pool[$urandom_range(POOL_SIZE - 1)];
                    it.message_number[lrud_pkg::LOWOFF_W-1:0] =
                        ($urandom_range(1) == 1) ? lrud_pkg::LOWOFF_W'($urandom_range(127, 120))
                                                 : lrud_pkg::LOWOFF_W'($urandom_range(127));
                    send_item(it, 1'b0, none);
                    sent++;
                    run_len = $urandom_range(10);
                    for (int k = 0; k < run_len; k++) begin
                        it.kind           = lrud_pkg::KIND_NEXT;
                        it.message_number = lrud_pkg::NUM_W'($urandom_range(16'hFFFF));
                        send_item(it, 1'b0, none);
                        sent++;
                    end
                end else if (pick < 90) begin
                    it.kind           = lrud_pkg::KIND_OPEN;
                    it.message_number = lrud_pkg::NUM_W'($urandom_range(16'hFFFF));
                    send_item(it, 1'b0, none);
                    sent++;
                end else begin
                    it.kind           = lrud_pkg::KIND_NEXT;
                    it.message_number = lrud_pkg::NUM_W'($urandom_range(16'hFFFF));
                    send_item(it, 1'b0, none);
                    sent++;
                end
            end
        end

        // let the last results come out, then wait quietly before finishing
        drain_results();
        repeat (ENTRIES + 4) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lrud_pkg.sv
rtl/core/lrud_cell.sv
rtl/core/message_block_lru_directory.sv
tb/sv/tb_message_block_lru_directory.sv
